/* design/tdpt_pkg.sv */
// Package for the trial-division prime test.
// Holds the sequencer state type; no dependencies.
package tdpt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST
  } tdpt_state_t;

endpackage

/* design/trial_division_prime_test.sv */
// Trial-division prime test: top level with sequencer and bit-serial remainder unit.
// Depends on tdpt_pkg for the sequencer state type.
//
// A user starts a test by raising start while busy is low; in_number is taken on
// that edge and only its low VALUE_WIDTH bits count. The result appears on
// out_is_prime for exactly one cycle, marked by out_valid, and must be taken then:
// the block does not wait for the receiver. Zero, one and even numbers are decided
// at once, with the result in the next cycle and busy staying low. Other numbers are
// tried against the odd trial divisors from 3 upward in turn: an odd prime is
// reported once the square of the next divisor exceeds the number, an odd composite
// once the first divisor that divides it is found. Each divisor costs one bound
// check, VALUE_WIDTH steps of the shared restoring remainder unit (one bit per
// cycle) and one zero test; the square of the divisor is kept by incremental adds,
// so there is no multiplier.
module trial_division_prime_test #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_number,
  output logic        out_valid,
  output logic        out_is_prime
);
  import tdpt_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int SW = VALUE_WIDTH + 2;
  localparam int CW = $clog2(VALUE_WIDTH);

  tdpt_state_t    state_r, state_nxt;
  logic [W-1:0]   n_r, n_nxt;
  logic [W-1:0]   d_r, d_nxt;
  logic [SW-1:0]  sq_r, sq_nxt;
  logic [W-1:0]   rem_r, rem_nxt;
  logic [W-1:0]   shf_r, shf_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           is_prime_r, is_prime_nxt;

  logic [W-1:0]   in_n;
  logic           in_trivial;
  logic           in_trivial_prime;
  logic [W:0]     rem_shift;
  logic [W:0]     rem_diff;
  logic           over_bound;

  assign in_n             = W'(in_number);
  assign in_trivial       = (in_n[W-1:1] == '0) || !in_n[0];
  assign in_trivial_prime = (in_n == W'(2));

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign rem_shift  = {rem_r, shf_r[W-1]};
  assign rem_diff   = rem_shift - {1'b0, d_r};
  assign over_bound = (sq_r > {2'b00, n_r});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && !in_trivial) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = over_bound ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_TEST;
      end
      ST_TEST: begin
        state_nxt = (rem_r == '0) ? ST_IDLE : ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    shf_nxt       = shf_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    is_prime_nxt  = is_prime_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt  = in_n;
          d_nxt  = W'(3);
          sq_nxt = SW'(9);
          if (in_trivial) begin
            out_valid_nxt = 1'b1;
            is_prime_nxt  = in_trivial_prime;
          end
        end
      end
      ST_CHECK: begin
        if (over_bound) begin
          out_valid_nxt = 1'b1;
          is_prime_nxt  = 1'b1;
        end else begin
          rem_nxt = '0;
          shf_nxt = n_r;
          cnt_nxt = CW'(W - 1);
        end
      end
      ST_DIV: begin
        rem_nxt = rem_diff[W] ? rem_shift[W-1:0] : rem_diff[W-1:0];
        shf_nxt = {shf_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
      end
      ST_TEST: begin
        if (rem_r == '0) begin
          out_valid_nxt = 1'b1;
          is_prime_nxt  = 1'b0;
        end else begin
          // (d+2)^2 = d^2 + 4d + 4
          d_nxt  = d_r + W'(2);
          sq_nxt = sq_r + {d_r, 2'b00} + SW'(4);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    shf_r      <= shf_nxt;
    cnt_r      <= cnt_nxt;
    is_prime_r <= is_prime_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = is_prime_r;

`ifndef SYNTHESIS
  // Trial divisors are always odd while a test runs.
  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> d_r[0])
    else $error("trial divisor is even");

  // The partial remainder stays below the divisor.
  a_rem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_TEST) |-> (rem_r < d_r))
    else $error("partial remainder not below divisor");

  // The incrementally kept square matches the divisor.
  a_sq_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (sq_r == (SW'(d_r) * SW'(d_r))))
    else $error("divisor square out of step");
`endif

endmodule
